// ===== src/ycintp_pkg.sv =====
// Shared types and constants for the yield curve interpolator.
// No dependencies; every other file in src imports this package.
package ycintp_pkg;

    // Curve table size default, queue depth and exp series term count
    localparam int MAX_NODES_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int EXP_TERMS     = 12;

    // ln(2) in Q.32 and range bounds for the exponent split
    localparam logic signed [63:0] LN2_Q32   = 64'sh0000_0000_B172_17F8;
    localparam logic signed [63:0] LN2_X4    = 64'sh0000_0002_C5C8_5FE0;
    localparam logic signed [63:0] LN2_X58   = 64'sh0000_0028_33D9_6E30;
    localparam logic [31:0]        ONE_Q28   = 32'h1000_0000;
    localparam logic [31:0]        DISC_SAT  = 32'hFFFF_FFFF;

    // Result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_ORDER = 3'd1;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [2:0] STAT_RATE_SAT  = 3'd3;
    localparam logic [2:0] STAT_DISC_SAT  = 3'd4;

    // Operation kinds, in opcode order
    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_QUERY     = 2'd1,
        OP_BUMP_NODE = 2'd2,
        OP_BUMP_ALL  = 2'd3
    } op_kind_t;

    // One queued operation
    typedef struct packed {
        op_kind_t           kind;
        logic [3:0]         node_index;
        logic [23:0]        time_point;
        logic signed [31:0] rate_value;
    } item_t;

    // Execution sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_Q_FIRST,
        ST_Q_LAST,
        ST_Q_SCAN,
        ST_Q_MUL,
        ST_Q_PREP,
        ST_Q_DIV,
        ST_Q_RATE,
        ST_D_MUL,
        ST_D_RANGE,
        ST_D_KDIV,
        ST_D_TMUL,
        ST_D_TDIV,
        ST_D_TACC,
        ST_D_ROUND,
        ST_B_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== src/ycintp_front.sv =====
// Front end: accepts input transactions, decodes the opcode and queues items.
// Depends on ycintp_pkg.
module ycintp_front
    import ycintp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // node_index[3:0], time_point[27:4], rate_value[59:28]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        q_valid,
    input  logic        q_pop,
    output item_t       q_item
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    item_t              q_mem [QUEUE_DEPTH];
    logic [PW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]        count_reg, count_next;
    logic               push;
    item_t              dec_item;

    // Classify the incoming transaction
    always_comb
    begin
        dec_item.node_index = s_tdata[3:0];
        dec_item.time_point = s_tdata[27:4];
        dec_item.rate_value = $signed(s_tdata[59:28]);
        dec_item.kind       = op_kind_t'(s_tuser);
    end

    assign s_tready = (count_reg != (PW+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
            count_next = count_reg + 1'b1;
        else if (!push && q_pop)
            count_next = count_reg - 1'b1;
    end

    // Queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= dec_item;
    end

endmodule

// ===== src/ycintp_exec.sv =====
// Back end: curve table, node search, interpolation divider, exp series and
// the result register. Depends on ycintp_pkg.
module ycintp_exec
    import ycintp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        q_valid,
    output logic        q_pop,
    input  item_t       q_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [2:0]  m_tuser
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    // Curve table
    logic [23:0]        ten_mem  [MAX_NODES];
    logic signed [31:0] rate_mem [MAX_NODES];

    state_t             state_reg, state_next;
    logic [4:0]         count_reg;
    item_t              item_reg;
    logic [CW-1:0]      i_reg;
    logic [23:0]        lo_reg, hi_reg;
    logic signed [31:0] r0_reg, r1_reg, rate_reg;
    logic signed [57:0] prod_reg;
    logic               neg_reg;
    logic [24:0]        rem_reg;
    logic [32:0]        quo_reg;
    logic [23:0]        div_reg;
    logic [5:0]         cnt_reg;
    logic signed [56:0] x_reg;
    logic [37:0]        fr_reg;
    logic [5:0]         kq_reg;
    logic [32:0]        term_reg;
    logic [34:0]        sum_reg;
    logic [3:0]         ti_reg;
    logic               found_reg, sat_reg;
    logic signed [31:0] res_rate_reg;
    logic [31:0]        res_disc_reg;
    logic [2:0]         res_status_reg;
    logic               m_valid_reg;
    logic [63:0]        m_data_reg;
    logic [2:0]         m_user_reg;

    logic [CW-1:0]      n_act;
    logic [IW-1:0]      n_last, rd_idx;
    logic [23:0]        rd_ten;
    logic signed [31:0] rd_rate;
    logic               t_le, t_ge, i_last, slot_ok, out_free;
    logic               ten_we, rate_we;
    logic [IW-1:0]      wr_idx;
    logic signed [31:0] wr_rate;
    logic               bad_order, bump_hit, bump_ovf;
    logic signed [32:0] bump_sum;
    logic signed [31:0] bump_val;
    logic [25:0]        rem2;
    logic               div_ge;
    logic [23:0]        d_val;
    logic signed [32:0] diff;
    logic [57:0]        mag, nnum;
    logic signed [33:0] r_sum;
    logic signed [57:0] y_neg;
    logic signed [63:0] y64;
    logic [2:0]         kj;
    logic [37:0]        ln2_sh;
    logic [64:0]        tprod;
    logic [5:0]         sh;
    logic [63:0]        rnd_sum, rnd_res;

    // Active node count, clamped to 1..MAX_NODES
    always_comb
    begin
        if (count_reg == 5'd0)
            n_act = CW'(1);
        else if (int'(count_reg) > MAX_NODES)
            n_act = CW'(MAX_NODES);
        else
            n_act = CW'(count_reg);
    end
    assign n_last = IW'(n_act - 1'b1);
    assign i_last = (i_reg == CW'(n_act - 1'b1));

    // Table read port
    assign rd_ten  = ten_mem[rd_idx];
    assign rd_rate = rate_mem[rd_idx];
    assign t_le    = (item_reg.time_point <= rd_ten);
    assign t_ge    = (item_reg.time_point >= rd_ten);

    // Load checks
    assign slot_ok   = (int'(item_reg.node_index) < MAX_NODES);
    assign bad_order = (item_reg.time_point == 24'd0)
                    || ((item_reg.node_index != 4'd0) && t_le);

    // Saturating bump
    assign bump_sum = {rd_rate[31], rd_rate} + {item_reg.rate_value[31], item_reg.rate_value};
    assign bump_ovf = (bump_sum[32] != bump_sum[31]);
    assign bump_val = bump_ovf ? (bump_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                               : bump_sum[31:0];
    assign bump_hit = (item_reg.kind == OP_BUMP_ALL) || (rd_ten == item_reg.time_point);

    // Shared restoring divider step
    assign rem2   = {rem_reg, quo_reg[32]};
    assign div_ge = (rem2 >= {2'b00, div_reg});

    // Interpolation operands
    assign d_val = (item_reg.time_point > lo_reg) ? (item_reg.time_point - lo_reg) : 24'd0;
    assign diff  = {r1_reg[31], r1_reg} - {r0_reg[31], r0_reg};
    assign mag   = prod_reg[57] ? 58'(-prod_reg) : 58'(prod_reg);
    assign nnum  = mag + 58'(hi_reg - lo_reg) / 58'd2;
    assign r_sum = neg_reg ? ({{2{r0_reg[31]}}, r0_reg} - $signed({2'b00, quo_reg[31:0]}))
                           : ({{2{r0_reg[31]}}, r0_reg} + $signed({2'b00, quo_reg[31:0]}));

    // Exponent split: y = -rate*t, floored to Q.32
    assign y_neg  = -$signed({x_reg[56], x_reg});
    assign y64    = 64'(y_neg >>> 8);
    assign kj     = 3'(cnt_reg - 1'b1);
    assign ln2_sh = 38'(LN2_Q32) << kj;
    assign tprod  = 65'(term_reg) * 65'(fr_reg[31:0]);
    assign sh     = 6'(7'd62 - {1'b0, kq_reg});
    assign rnd_sum = 64'(sum_reg) + (64'd1 << (sh - 1'b1));
    assign rnd_res = rnd_sum >> sh;

    assign out_free = !m_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    unique case (q_item.kind)
                        OP_LOAD:  state_next = ST_LOAD;
                        OP_QUERY: state_next = ST_Q_FIRST;
                        default:  state_next = ST_B_SCAN;
                    endcase
                end
            ST_LOAD:    state_next = ST_DONE;
            ST_Q_FIRST: state_next = t_le ? ST_D_MUL : ST_Q_LAST;
            ST_Q_LAST:  state_next = t_ge ? ST_D_MUL : ST_Q_SCAN;
            ST_Q_SCAN:
                if (i_reg != '0)
                begin
                    if (t_le)
                        state_next = (rd_ten <= lo_reg) ? ST_D_MUL : ST_Q_MUL;
                    else if (i_last)
                        state_next = ST_D_MUL;
                end
            ST_Q_MUL:   state_next = ST_Q_PREP;
            ST_Q_PREP:  state_next = ST_Q_DIV;
            ST_Q_DIV:   state_next = (cnt_reg == 6'd1) ? ST_Q_RATE : ST_Q_DIV;
            ST_Q_RATE:  state_next = ST_D_MUL;
            ST_D_MUL:   state_next = (item_reg.time_point == 24'd0) ? ST_DONE : ST_D_RANGE;
            ST_D_RANGE:
                if (y64 >= LN2_X4 || y64 < -LN2_X58)
                    state_next = ST_DONE;
                else
                    state_next = ST_D_KDIV;
            ST_D_KDIV:  state_next = (cnt_reg == 6'd1) ? ST_D_TMUL : ST_D_KDIV;
            ST_D_TMUL:  state_next = ST_D_TDIV;
            ST_D_TDIV:  state_next = (cnt_reg == 6'd1) ? ST_D_TACC : ST_D_TDIV;
            ST_D_TACC:  state_next = (ti_reg == 4'(EXP_TERMS)) ? ST_D_ROUND : ST_D_TMUL;
            ST_D_ROUND: state_next = ST_DONE;
            ST_B_SCAN:  state_next = i_last ? ST_DONE : ST_B_SCAN;
            ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control outputs: queue pop, table read address and writes
    always_comb
    begin
        q_pop   = 1'b0;
        rd_idx  = i_reg[IW-1:0];
        ten_we  = 1'b0;
        rate_we = 1'b0;
        wr_idx  = i_reg[IW-1:0];
        wr_rate = bump_val;
        unique case (state_reg)
            ST_IDLE:    q_pop = q_valid;
            ST_LOAD:
            begin
                rd_idx  = IW'(item_reg.node_index - 4'd1);
                wr_idx  = IW'(item_reg.node_index);
                wr_rate = item_reg.rate_value;
                ten_we  = slot_ok;
                rate_we = slot_ok;
            end
            ST_Q_FIRST: rd_idx = '0;
            ST_Q_LAST:  rd_idx = n_last;
            ST_B_SCAN:  rate_we = bump_hit;
            default:    rd_idx = i_reg[IW-1:0];
        endcase
    end

    // Table writes
    always_ff @(posedge clk)
    begin
        if (ten_we)
            ten_mem[wr_idx] <= item_reg.time_point;
        if (rate_we)
            rate_mem[wr_idx] <= wr_rate;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= 5'd1;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;
            if (state_reg == ST_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                item_reg       <= q_item;
                i_reg          <= '0;
                found_reg      <= 1'b0;
                sat_reg        <= 1'b0;
                res_rate_reg   <= '0;
                res_disc_reg   <= '0;
                res_status_reg <= STAT_OK;
            end
            ST_LOAD:
                res_status_reg <= (slot_ok && bad_order) ? STAT_BAD_ORDER : STAT_OK;
            ST_Q_FIRST, ST_Q_LAST:
                rate_reg <= rd_rate;
            ST_Q_SCAN:
            begin
                if (i_reg == '0 || (!t_le && !i_last))
                begin
                    lo_reg <= rd_ten;
                    r0_reg <= rd_rate;
                    i_reg  <= i_reg + 1'b1;
                end
                hi_reg   <= rd_ten;
                r1_reg   <= rd_rate;
                rate_reg <= rd_rate;
            end
            ST_Q_MUL:
                prod_reg <= diff * $signed({1'b0, d_val});
            ST_Q_PREP:
            begin
                neg_reg <= prod_reg[57];
                rem_reg <= nnum[56:32];
                quo_reg <= {nnum[31:0], 1'b0};
                div_reg <= hi_reg - lo_reg;
                cnt_reg <= 6'd32;
            end
            ST_Q_DIV, ST_D_TDIV:
            begin
                rem_reg <= div_ge ? 25'(rem2 - {2'b00, div_reg}) : rem2[24:0];
                quo_reg <= {quo_reg[31:0], div_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_Q_RATE:
                rate_reg <= r_sum[31:0];
            ST_D_MUL:
            begin
                x_reg        <= rate_reg * $signed({1'b0, item_reg.time_point});
                res_rate_reg <= rate_reg;
                res_disc_reg <= ONE_Q28;
            end
            ST_D_RANGE:
            begin
                fr_reg  <= 38'(y64 + LN2_X58);
                kq_reg  <= '0;
                cnt_reg <= 6'd6;
                if (y64 >= LN2_X4)
                begin
                    res_disc_reg   <= DISC_SAT;
                    res_status_reg <= STAT_DISC_SAT;
                end
                else
                    res_disc_reg <= '0;
            end
            ST_D_KDIV:
            begin
                if (fr_reg >= ln2_sh)
                begin
                    fr_reg     <= fr_reg - ln2_sh;
                    kq_reg[kj] <= 1'b1;
                end
                cnt_reg  <= cnt_reg - 1'b1;
                term_reg <= 33'h1_0000_0000;
                sum_reg  <= 35'h1_0000_0000;
                ti_reg   <= 4'd1;
            end
            ST_D_TMUL:
            begin
                quo_reg <= tprod[64:32];
                rem_reg <= '0;
                div_reg <= 24'(ti_reg);
                cnt_reg <= 6'd33;
            end
            ST_D_TACC:
            begin
                term_reg <= quo_reg;
                sum_reg  <= sum_reg + 35'(quo_reg);
                ti_reg   <= ti_reg + 1'b1;
            end
            ST_D_ROUND:
            begin
                if (rnd_res > 64'(DISC_SAT))
                begin
                    res_disc_reg   <= DISC_SAT;
                    res_status_reg <= STAT_DISC_SAT;
                end
                else
                    res_disc_reg <= rnd_res[31:0];
            end
            ST_B_SCAN:
            begin
                i_reg <= i_reg + 1'b1;
                if (bump_hit)
                    found_reg <= 1'b1;
                if (bump_hit && bump_ovf)
                    sat_reg <= 1'b1;
                if (i_last)
                begin
                    if (item_reg.kind == OP_BUMP_NODE && !(found_reg || bump_hit))
                        res_status_reg <= STAT_NOT_FOUND;
                    else if (sat_reg || (bump_hit && bump_ovf))
                        res_status_reg <= STAT_RATE_SAT;
                    else
                        res_status_reg <= STAT_OK;
                end
            end
            ST_DONE:
                if (out_free)
                begin
                    m_data_reg <= {res_disc_reg, res_rate_reg};
                    m_user_reg <= res_status_reg;
                end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== src/yield_curve_interpolator_core.sv =====
// Top level of the yield curve interpolator: front queue plus execution unit.
// Depends on ycintp_pkg, ycintp_front and ycintp_exec.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | tdata: index, time, rate; tuser: opcode
//  m_*     | out | m_tvalid/m_tready | tdata: rate_out, discount_out; tuser: status
//  cfg_*   | in  | cfg_wr_en         | cfg_wr_data: node_count
//
// Load writes one table entry; a bump scans the table one entry per cycle.
// A query may run the 32-step interpolation divide and the twelve exp terms,
// each a multiply plus a 33-step divide in the shared divider.
// A two-entry queue lets the front accept while the back works; the result
// register holds a transaction until m_tready. Reset clears control only.
module yield_curve_interpolator_core
    import ycintp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // node_count[4:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // node_index[3:0], time_point[27:4], rate_value[59:28]
    input  logic [1:0]  s_tuser,       // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // rate_out[31:0], discount_out[63:32]
    output logic [2:0]  m_tuser        // status[2:0]
);

    logic  q_valid, q_pop;
    item_t q_item;

    ycintp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    ycintp_exec #(
        .MAX_NODES (MAX_NODES)
    ) u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // An accepted transaction is always visible to the back end next cycle
    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> q_valid)
        else $error("accepted transaction lost from queue");

    // Never pop an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // A discount saturation status carries the saturated discount value
    a_disc_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STAT_DISC_SAT) |-> (m_tdata[63:32] == DISC_SAT))
        else $error("discount saturation status without saturated value");

    // Load and bump error results carry no rate or discount
    a_nonquery_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STAT_BAD_ORDER || m_tuser == STAT_NOT_FOUND
                      || m_tuser == STAT_RATE_SAT)) |-> (m_tdata == 64'd0))
        else $error("non-query result with nonzero payload");

endmodule
